/* design/majority_element_histogram_defines.svh */
// Assertion macros used by the datapath.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef MAJORITY_ELEMENT_HISTOGRAM_DEFINES_SVH
`define MAJORITY_ELEMENT_HISTOGRAM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/meh_pkg.sv */
`timescale 1ns / 1ps

package meh_pkg;

    localparam int VALUE_W = 8;

    typedef logic [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic scan_init;
        logic scan_run;
        logic res_latch;
        logic out_load;
        logic set_clear;
    } t_ctrl_cmd;

    typedef struct packed {
        logic b_last;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } t_ctrl_status;

endpackage

/* design/meh_channels.sv */
`timescale 1ns / 1ps

interface meh_in_if;
    import meh_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;
    logic   last;

    modport source (output valid, value, last, input ready);
    modport sink (input valid, value, last, output ready);
endinterface

interface meh_out_if;
    import meh_pkg::*;

    logic   valid;
    logic   ready;
    logic   found;
    t_value majority_value;

    modport source (output valid, found, majority_value, input ready);
    modport sink (input valid, found, majority_value, output ready);
endinterface

/* design/majority_element_histogram.sv */
`timescale 1ns / 1ps
// Majority value finder over sets of 8-bit values.
// Input channel i_in carries one value per item and a last flag on the final
// item of a set. Output channel o_out carries one item per set: found, and the
// smallest value whose count exceeds half the set size (0 when none exists).
// Within a set the block takes one item per cycle; a histogram increment that
// hits the entry written in the previous cycle is forwarded around the memory.
// After the last item is taken, input stalls while the histogram is scanned
// one entry per cycle through the single memory read port, stopping at the
// first hit. o_out.valid rises once the scan has stopped and the output
// register is free, and the first item of the next set can be taken in that
// same cycle at the earliest.
// The result sits in an output register: a stalled receiver holds it, and the
// next set streams in meanwhile; its scan result waits until the register
// frees. The histogram and item count clear when each answer is loaded out.
// Reset clears the histogram valid bits, the item count and all control state.
// Counts saturate at MAX_ITEMS; values at or above VALUE_RANGE count as items
// only.

module majority_element_histogram #(
    parameter int VALUE_RANGE = 256,
    parameter int MAX_ITEMS   = 4096
) (
    input logic i_clk,
    input logic i_rst_n,
    meh_in_if.sink    i_in,
    meh_out_if.source o_out
);
    import meh_pkg::*;

    t_ctrl_cmd    cmd;
    t_ctrl_status st;
    logic         in_ready;
    logic         accept;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    meh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    meh_datapath #(
        .VALUE_RANGE (VALUE_RANGE),
        .MAX_ITEMS   (MAX_ITEMS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_accept    (accept),
        .i_value     (i_in.value),
        .i_last      (i_in.last),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_found     (o_out.found),
        .o_value     (o_out.majority_value)
    );

endmodule

/* design/meh_ctrl.sv */
`timescale 1ns / 1ps

module meh_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  meh_pkg::t_ctrl_status i_st,
    output meh_pkg::t_ctrl_cmd    o_cmd,
    output logic                 o_in_ready
);
    import meh_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SCAN,
        ST_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   scan_stop;

    assign scan_stop = i_st.scan_hit || i_st.scan_end;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            ST_RUN: begin
                o_in_ready      = !i_st.b_last;
                o_cmd.scan_init = i_st.b_last;
                if (i_st.b_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run  = !scan_stop;
                o_cmd.res_latch = scan_stop;
                if (scan_stop) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                o_cmd.out_load  = i_st.out_free;
                o_cmd.set_clear = i_st.out_free;
                if (i_st.out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/meh_datapath.sv */
`timescale 1ns / 1ps
`include "majority_element_histogram_defines.svh"

module meh_datapath #(
    parameter int VALUE_RANGE = 256,
    parameter int MAX_ITEMS   = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  meh_pkg::t_ctrl_cmd    i_cmd,
    output meh_pkg::t_ctrl_status o_st,
    input  logic                 i_accept,
    input  meh_pkg::t_value       i_value,
    input  logic                 i_last,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_found,
    output meh_pkg::t_value       o_value
);
    import meh_pkg::*;

    localparam int DEPTH = (VALUE_RANGE < 256) ? VALUE_RANGE : 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0]      MAX_C     = CW'(MAX_ITEMS);
    localparam logic [VALUE_W:0]   DEPTH_V   = (VALUE_W + 1)'(DEPTH);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);

    logic [CW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [CW-1:0] r_rdata;
    logic          r_rvld;

    logic          r_b_vld;
    t_value        r_b_val;
    logic          r_b_last;

    logic          r_fwd_vld;
    logic [AW-1:0] r_fwd_addr;
    logic [CW-1:0] r_fwd_data;

    logic [CW-1:0] r_item_count;
    logic [CW-1:0] n_item_count;

    logic [AW-1:0] r_scan_idx;
    logic          r_scan_more;
    logic [AW-1:0] r_cmp_idx;
    logic          r_cmp_vld;

    logic          r_res_found;
    t_value        r_res_val;
    logic          r_out_valid;
    logic          r_out_found;
    t_value        r_out_val;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [CW-1:0] cur_count;
    logic [CW-1:0] n_wdata;
    logic [CW-1:0] cmp_count;
    logic          scan_hit;
    logic          scan_end;

    assign rd_addr  = i_cmd.scan_run ? r_scan_idx : i_value[AW-1:0];
    assign wr_addr  = r_b_val[AW-1:0];
    assign wr_en    = r_b_vld && ({1'b0, r_b_val} < DEPTH_V);

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == wr_addr)) begin
            cur_count = r_fwd_data;
        end else if (r_rvld) begin
            cur_count = r_rdata;
        end else begin
            cur_count = '0;
        end
        n_wdata      = (cur_count == MAX_C) ? MAX_C : cur_count + 1'b1;
        n_item_count = (r_item_count == MAX_C) ? MAX_C : r_item_count + 1'b1;
        cmp_count    = r_rvld ? r_rdata : '0;
    end

    assign scan_hit = r_cmp_vld && (cmp_count > (r_item_count >> 1));
    assign scan_end = r_cmp_vld && (r_cmp_idx == LAST_ADDR);

    assign o_st.b_last   = r_b_vld && r_b_last;
    assign o_st.scan_hit = scan_hit;
    assign o_st.scan_end = scan_end;
    assign o_st.out_free = !r_out_valid || i_out_ready;

    // Histogram storage, one read and one write port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= n_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[rd_addr];
            if (i_cmd.set_clear) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_val    <= i_value;
        r_b_last   <= i_last;
        r_fwd_addr <= wr_addr;
        r_fwd_data <= n_wdata;
        if (!i_rst_n) begin
            r_b_vld      <= 1'b0;
            r_fwd_vld    <= 1'b0;
            r_item_count <= '0;
        end else begin
            r_b_vld   <= i_accept;
            r_fwd_vld <= wr_en;
            if (i_cmd.set_clear) begin
                r_item_count <= '0;
            end else if (i_accept) begin
                r_item_count <= n_item_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx  <= '0;
            r_scan_more <= 1'b0;
            r_cmp_idx   <= '0;
            r_cmp_vld   <= 1'b0;
        end else begin
            if (i_cmd.scan_init) begin
                r_scan_idx  <= '0;
                r_scan_more <= 1'b1;
                r_cmp_vld   <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_cmp_vld <= r_scan_more;
                r_cmp_idx <= r_scan_idx;
                if (r_scan_more) begin
                    r_scan_idx  <= r_scan_idx + 1'b1;
                    r_scan_more <= (r_scan_idx != LAST_ADDR);
                end
            end else begin
                r_scan_more <= 1'b0;
                r_cmp_vld   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_latch) begin
            r_res_found <= scan_hit;
            r_res_val   <= scan_hit ? VALUE_W'(r_cmp_idx) : '0;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_res_found;
            r_out_val   <= r_res_val;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_value     = r_out_val;

    `MEH_ASSERT_IMP(a_scan_no_item, r_cmp_vld, !r_b_vld, "item in flight during scan")
    `MEH_ASSERT_IMP(a_load_free, i_cmd.out_load, !r_out_valid || i_out_ready,
        "result loaded over a pending result")
    `MEH_ASSERT_NXT(a_latch_stops, i_cmd.res_latch, !r_cmp_vld && !r_scan_more,
        "scan still active after result latch")
    `MEH_ASSERT_NXT(a_clear_count, i_cmd.set_clear, r_item_count == '0 && r_vld == '0,
        "histogram not cleared after result")

endmodule

/* tb/majority_scoreboard.sv */
`timescale 1ns / 1ps

module majority_scoreboard #(
    parameter int VALUE_RANGE = 256,
    parameter int MAX_ITEMS   = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    meh_in_if    i_in,
    meh_out_if   i_out,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_sets,
    output int   o_majorities
);
    import meh_pkg::*;

    localparam int SCAN_LIMIT = (VALUE_RANGE < 256) ? VALUE_RANGE : 256;

    typedef struct packed {
        logic   found;
        t_value majority_value;
    } t_answer;

    logic [12:0] value_counts [VALUE_RANGE];
    logic [12:0] set_size;
    t_answer     answers_due [$];
    int          mismatch_count = 0;
    int          pending_count = 0;
    int          set_count = 0;
    int          majority_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;
    assign o_sets       = set_count;
    assign o_majorities = majority_count;

    function automatic logic [12:0] saturating_bump(input logic [12:0] count);
        return (count < MAX_ITEMS) ? count + 13'd1 : 13'(MAX_ITEMS);
    endfunction

    task automatic clear_set();
        foreach (value_counts[k]) value_counts[k] = '0;
        set_size = '0;
    endtask

    task automatic count_value(input t_value value, input logic last);
        t_answer     answer;
        logic [12:0] half;
        set_size = saturating_bump(set_size);
        if (int'(value) < VALUE_RANGE) begin
            value_counts[value] = saturating_bump(value_counts[value]);
        end
        if (last) begin
            answer = '0;
            half   = set_size >> 1;
            for (int k = 0; k < SCAN_LIMIT; k++) begin
                if (value_counts[k] > half) begin
                    answer.found          = 1'b1;
                    answer.majority_value = t_value'(k);
                    break;
                end
            end
            answers_due.insert(answers_due.size(), answer);
            set_count++;
            if (answer.found) majority_count++;
            clear_set();
        end
    endtask

    task automatic compare_answer(input logic found, input t_value majority_value);
        t_answer want;
        if (answers_due.size() == 0) begin
            $error("Unexpected result: found %0d, majority_value %0d",
                   found, majority_value);
            mismatch_count++;
        end else begin
            want = answers_due.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, found);
                mismatch_count++;
            end
            if (majority_value !== want.majority_value) begin
                $error("majority_value: expected %0d, actual %0d",
                       want.majority_value, majority_value);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_set();
            answers_due.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                count_value(i_in.value, i_in.last);
            end
            if (i_out.valid && i_out.ready) begin
                compare_answer(i_out.found, i_out.majority_value);
            end
        end
        pending_count = answers_due.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import meh_pkg::*;

    localparam int          RANDOM_ITEMS = 600;
    localparam int          QUIET_AFTER  = 480;
    localparam int unsigned STALL_LIMIT  = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic quiet = 1'b0;
    int   gap_rate = 0;
    int   items_sent = 0;
    int   mismatches;
    int   pending;
    int   sets_done;
    int   majorities;
    int unsigned idle_cycles = 0;

    meh_in_if  in_ch ();
    meh_out_if out_ch ();

    majority_element_histogram dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    majority_scoreboard scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_sets       (sets_done),
        .o_majorities (majorities)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned stall_left;
        int unsigned calm_left;
        stall_left   = 0;
        calm_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet || calm_left != 0) begin
                if (calm_left != 0) calm_left--;
                out_ch.ready <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 10);
                out_ch.ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) calm_left = $urandom_range(20, 80);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input t_value value, input logic last);
        if (!quiet && gap_rate != 0 && $urandom_range(0, gap_rate) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.last  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_set(input t_value values[$]);
        gap_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
        foreach (values[k]) send_item(values[k], k == values.size() - 1);
    endtask

    task automatic make_random_set(output t_value values[$]);
        int     mode;
        int     len;
        int     bias;
        t_value favorite;
        t_value pool [3];
        values   = {};
        mode     = $urandom_range(0, 9);
        len      = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 24);
        favorite = t_value'($urandom_range(0, 255));
        bias     = $urandom_range(40, 85);
        foreach (pool[k]) pool[k] = t_value'($urandom_range(0, 255));
        if (mode <= 5) begin
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < bias) values.insert(values.size(), favorite);
                else values.insert(values.size(), t_value'($urandom_range(0, 255)));
            end
        end else if (mode <= 7) begin
            for (int k = 0; k < len; k++) begin
                values.insert(values.size(), pool[$urandom_range(0, 2)]);
            end
        end else if (mode == 8) begin
            for (int k = 0; k < len; k++) begin
                values.insert(values.size(), t_value'($urandom_range(0, 255)));
            end
        end else begin
            // Exactly half the set holds one value, which is not a majority.
            for (int k = 0; k < (len + 1) / 2; k++) begin
                values.insert($urandom_range(0, values.size()), favorite);
                values.insert($urandom_range(0, values.size()), favorite ^ t_value'(k + 1));
            end
        end
    endtask

    initial begin
        t_value values[$];
        int     random_items;
        int     set_index;
        random_items = 0;
        set_index    = 0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        in_ch.last   = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_set({8'd0});
        send_set({8'd255});
        send_set({8'd3, 8'd7});
        send_set({8'd255, 8'd255});
        send_set({8'd1, 8'd2, 8'd1});
        send_set({8'd5, 8'd9, 8'd9, 8'd5});
        send_set({8'd128, 8'd128, 8'd128, 8'd0, 8'd0});
        send_set({8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60});
        send_set({8'hAA, 8'h55, 8'h55});
        send_set({8'd7});

        while (random_items < RANDOM_ITEMS) begin
            make_random_set(values);
            send_set(values);
            random_items += values.size();
            set_index++;
            if (set_index == 12) begin
                in_ch.valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            if (random_items >= QUIET_AFTER) quiet = 1'b1;
        end

        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (300) @(posedge i_clk);

        $display("Sent %0d items in %0d sets; %0d sets had a majority value.",
                 items_sent, sets_done, majorities);
        $display("Covered extreme values, ties, exact halves and random stalls.");
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
